/* rtl/spdnlg_pkg.sv */
// spdnlg_pkg: types, constants and the microcode program of the steering drive controller
// no dependencies; used by spdnlg_seq and the top level
package spdnlg_pkg;

  localparam int OFFSET_W = 16;
  localparam int DRIVE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int WEIGHT_W = 9;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam int ERR_W    = 21;  // |e| <= 699050
  localparam int ERRMAG_W = 20;
  localparam int DIFF_W   = 22;
  localparam int QUO_W    = 31;  // (e*e) >> 8 < 2^31
  localparam int REM_W    = 16;
  localparam int DCNT_W   = 5;
  localparam int STEP_W   = 4;

  localparam int P1_W  = 53;
  localparam int P2_W  = 39;
  localparam int ACC_W = 54;
  localparam int FLT_W = 27;

  // floor(x/3) = (x * RECIP3) >> 24 for x < 2^23
  localparam logic [22:0] RECIP3 = 23'd5592406;

  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(QUO_W);

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd2048;
  localparam logic [GAIN_W-1:0]   SQ_DIV_RST      = 16'd10000;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 16'd0;
  localparam logic [WEIGHT_W-1:0] FILT_WEIGHT_RST = 9'd51;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 9'd256;

  typedef enum logic [1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_SQ_DIV      = 2'd1,
    REG_DERIV_GAIN  = 2'd2,
    REG_FILT_WEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_ERR,
    OP_SQ,
    OP_DIV,
    OP_GAIN,
    OP_MUL,
    OP_ACC,
    OP_FILT,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_DIV,
    COND_OUT
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t next;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic div_last;
    logic out_free;
  } stat_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      4'd0:    w = '{op: OP_WAIT, cond: COND_IN,     next: 4'd1};
      4'd1:    w = '{op: OP_ERR,  cond: COND_ALWAYS, next: 4'd2};
      4'd2:    w = '{op: OP_SQ,   cond: COND_ALWAYS, next: 4'd3};
      4'd3:    w = '{op: OP_DIV,  cond: COND_DIV,    next: 4'd4};
      4'd4:    w = '{op: OP_GAIN, cond: COND_ALWAYS, next: 4'd5};
      4'd5:    w = '{op: OP_MUL,  cond: COND_ALWAYS, next: 4'd6};
      4'd6:    w = '{op: OP_ACC,  cond: COND_ALWAYS, next: 4'd7};
      4'd7:    w = '{op: OP_FILT, cond: COND_ALWAYS, next: 4'd8};
      4'd8:    w = '{op: OP_EMIT, cond: COND_OUT,    next: 4'd0};
      default: w = '{op: OP_WAIT, cond: COND_ALWAYS, next: 4'd0};
    endcase
    return w;
  endfunction

endpackage

/* rtl/spdnlg_seq.sv */
// spdnlg_seq: step counter and microcode table lookup
// depends on spdnlg_pkg
module spdnlg_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  spdnlg_pkg::stat_t  stat,
  output spdnlg_pkg::ctrl_t  ctrl
);
  import spdnlg_pkg::*;

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   adv;

  assign uw = ucode(step_r);

  // next step
  always_comb begin
    case (uw.cond)
      COND_ALWAYS: adv = 1'b1;
      COND_IN:     adv = stat.in_fire;
      COND_DIV:    adv = stat.div_last;
      COND_OUT:    adv = stat.out_free;
      default:     adv = 1'b1;
    endcase
    step_nxt = adv ? uw.next : step_r;
  end

  // control outputs
  always_comb begin
    ctrl.op       = uw.op;
    ctrl.in_ready = (uw.op == OP_WAIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/steering_pd_nonlinear_gain_filtered_top.sv */
// steering drive: nonlinear-gain pd controller with first-order low-pass output filter
// per request: error, square, bit-serial divide, gain, multiply, accumulate, filter, emit
// a new request is taken once the last result is emitted, also while that result waits
// reset (rst_n low, synchronous): registers return to defaults, previous error and drive clear
// depends on spdnlg_pkg and spdnlg_seq
module steering_pd_nonlinear_gain_filtered_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [spdnlg_pkg::OFFSET_W-1:0] in_lane_offset,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [spdnlg_pkg::DRIVE_W-1:0]  out_steer_drive,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [spdnlg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spdnlg_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import spdnlg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  logic [GAIN_W-1:0]   prop_gain_r, sq_div_r, deriv_gain_r;
  logic [WEIGHT_W-1:0] filt_weight_r;

  logic signed [OFFSET_W-1:0] off_r;
  logic signed [ERR_W-1:0]    e_r, prev_err_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic [QUO_W-1:0]           quo_r;
  logic [REM_W-1:0]           rem_r, divisor_r;
  logic [DCNT_W-1:0]          dcnt_r;
  logic [QUO_W-1:0]           gain_r;
  logic signed [P1_W-1:0]     p1_r;
  logic signed [P2_W-1:0]     p2_r;
  logic signed [DRIVE_W-1:0]  raw_r, res_r, prev_drive_r, out_data_r;
  logic                       out_valid_r;

  logic in_fire, out_free, emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.in_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (ctrl.op == OP_EMIT) && out_free;

  assign stat.in_fire  = in_fire;
  assign stat.div_last = (dcnt_r == DCNT_W'(1));
  assign stat.out_free = out_free;

  spdnlg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= PROP_GAIN_RST;
      sq_div_r      <= SQ_DIV_RST;
      deriv_gain_r  <= DERIV_GAIN_RST;
      filt_weight_r <= FILT_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_W'(REG_PROP_GAIN):   prop_gain_r   <= cfg_data;
        CFG_IDX_W'(REG_SQ_DIV):      sq_div_r      <= cfg_data;
        CFG_IDX_W'(REG_DERIV_GAIN):  deriv_gain_r  <= cfg_data;
        CFG_IDX_W'(REG_FILT_WEIGHT): filt_weight_r <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // error: -offset*256/12 = -(|offset|*64)/3 with sign
  logic [OFFSET_W:0]        abs_off;
  logic [22:0]              recip_x;
  logic [45:0]              recip_p;
  logic [ERRMAG_W-1:0]      e_mag_q;
  logic signed [ERR_W-1:0]  e_nxt;

  always_comb begin
    abs_off = off_r[OFFSET_W-1] ? (OFFSET_W+1)'(-$signed({off_r[OFFSET_W-1], off_r}))
                                : {1'b0, off_r};
    recip_x = {abs_off, 6'b0};
    recip_p = 46'(recip_x) * 46'(RECIP3);
    e_mag_q = recip_p[43:24];
    e_nxt   = off_r[OFFSET_W-1] ? $signed({1'b0, e_mag_q})
                                : -$signed({1'b0, e_mag_q});
  end

  // squared error
  logic [ERRMAG_W-1:0] e_mag;
  logic [39:0]         sq;

  always_comb begin
    e_mag = e_r[ERR_W-1] ? ERRMAG_W'(-e_r) : ERRMAG_W'(e_r);
    sq    = 40'(e_mag) * 40'(e_mag);
  end

  // restoring divider, one quotient bit per step
  logic [REM_W:0] rem_sh;
  logic           q_bit;

  always_comb begin
    rem_sh = {rem_r, quo_r[QUO_W-1]};
    q_bit  = (rem_sh >= {1'b0, divisor_r});
  end

  // accumulate, truncate toward zero, saturate
  logic signed [ACC_W-1:0]    acc, acc_adj;
  logic signed [ACC_W-17:0]   acc_q;
  logic signed [DRIVE_W-1:0]  raw_nxt;

  always_comb begin
    acc     = ACC_W'(p1_r) + ACC_W'(p2_r);
    acc_adj = acc + (acc[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
    acc_q   = acc_adj[ACC_W-1:16];
    if (acc_q > $signed((ACC_W-16)'(32767)))
      raw_nxt = 16'sh7FFF;
    else if (acc_q < -$signed((ACC_W-16)'(32768)))
      raw_nxt = 16'sh8000;
    else
      raw_nxt = acc_q[DRIVE_W-1:0];
  end

  // low-pass blend with previous drive
  logic [WEIGHT_W-1:0]       w_eff;
  logic signed [9:0]         w_s, w_inv;
  logic signed [FLT_W-1:0]   flt, flt_adj;
  logic signed [DRIVE_W-1:0] res_nxt;

  always_comb begin
    w_eff   = (filt_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : filt_weight_r;
    w_s     = $signed({1'b0, w_eff});
    w_inv   = $signed({1'b0, WEIGHT_ONE}) - w_s;
    flt     = FLT_W'(w_inv) * FLT_W'(raw_r) + FLT_W'(w_s) * FLT_W'(prev_drive_r);
    flt_adj = flt + (flt[FLT_W-1] ? FLT_W'(255) : FLT_W'(0));
    res_nxt = flt_adj[23:8];
  end

  // datapath registers driven by the current control word
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_WAIT: begin
        if (in_fire) off_r <= in_lane_offset;
      end
      OP_ERR: begin
        e_r <= e_nxt;
      end
      OP_SQ: begin
        quo_r     <= sq[38:8];
        rem_r     <= '0;
        divisor_r <= (sq_div_r == '0) ? REM_W'(1) : sq_div_r;
        dcnt_r    <= DIV_STEPS;
        diff_r    <= DIFF_W'(e_r) - DIFF_W'(prev_err_r);
      end
      OP_DIV: begin
        rem_r  <= q_bit ? REM_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[REM_W-1:0];
        quo_r  <= {quo_r[QUO_W-2:0], q_bit};
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      OP_GAIN: begin
        gain_r <= QUO_W'(32'(quo_r) + 32'(prop_gain_r));
      end
      OP_MUL: begin
        p1_r <= P1_W'($signed({1'b0, gain_r})) * P1_W'(e_r);
        p2_r <= P2_W'($signed({1'b0, deriv_gain_r})) * P2_W'(diff_r);
      end
      OP_ACC: begin
        raw_r <= raw_nxt;
      end
      OP_FILT: begin
        res_r <= res_nxt;
      end
      OP_EMIT: begin
        if (out_free) out_data_r <= res_r;
      end
      default: ;
    endcase
  end

  // controller state and output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r   <= '0;
      prev_drive_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit) begin
        prev_err_r   <= e_r;
        prev_drive_r <= res_r;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_steer_drive = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (ctrl.op == OP_ERR))
    else $error("accepted request did not start the error step");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV) |-> (dcnt_r != '0))
    else $error("divider step with exhausted count");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV) |-> (rem_r < divisor_r))
    else $error("divider remainder not below divisor");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == OP_EMIT))
    else $error("result appeared outside the emit step");

endmodule

/* tb/sv/steering_pd_nonlinear_gain_filtered_top_tb.sv */
// self-checking testbench for steering_pd_nonlinear_gain_filtered_top: drives lane offsets
// and register writes, predicts each steering drive and compares it in order
// depends on spdnlg_pkg and the steering_pd_nonlinear_gain_filtered_top rtl
module steering_pd_nonlinear_gain_filtered_top_tb;
  import spdnlg_pkg::*;

  localparam int ERR_FRAC      = 8;
  localparam int GAIN_FRAC     = 8;
  localparam int NUM_REGS      = 4;
  localparam int HOLD_CYCLES   = 600;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 175;
  localparam int RAND_PHASES   = 10;
  localparam int SETTLE_CYCLES = 40;

  class drive_scoreboard;
    longint prop_gain, sq_div, deriv_gain, filt_weight;
    longint last_err, last_drive;
    logic signed [DRIVE_W-1:0] expected_drives[$];
    int unsigned failures;

    function new();
      prop_gain   = PROP_GAIN_RST;
      sq_div      = SQ_DIV_RST;
      deriv_gain  = DERIV_GAIN_RST;
      filt_weight = FILT_WEIGHT_RST;
      last_err    = 0;
      last_drive  = 0;
      failures    = 0;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    // writes to indexes past the register file are dropped
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:   prop_gain = data;
        REG_SQ_DIV:      sq_div = data;
        REG_DERIV_GAIN:  deriv_gain = data;
        REG_FILT_WEIGHT: filt_weight = data & 16'h01FF;
        default: ;
      endcase
    endfunction

    function void note_request(logic signed [OFFSET_W-1:0] offset);
      longint err, mag, div, sq_gain, gain, acc, raw, w, blend;
      err = (-longint'(offset) * (longint'(1) << ERR_FRAC)) / 12;
      mag = (err < 0) ? -err : err;
      div = (sq_div == 0) ? 1 : sq_div;
      sq_gain = (mag * mag) / (div << (2 * ERR_FRAC - GAIN_FRAC));
      if (sq_gain > 64'h7FFFFFFF) sq_gain = 64'h7FFFFFFF;
      gain = sq_gain + prop_gain;
      if (gain > 64'h7FFFFFFF) gain = 64'h7FFFFFFF;
      acc = gain * err + deriv_gain * (err - last_err);
      raw = clamp16(acc / (longint'(1) << (ERR_FRAC + GAIN_FRAC)));
      w = (filt_weight > 256) ? 256 : filt_weight;
      blend = clamp16(((256 - w) * raw + w * last_drive) / 256);
      last_err = err;
      last_drive = blend;
      expected_drives.push_back(DRIVE_W'(blend));
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] actual);
      logic signed [DRIVE_W-1:0] want;
      if (expected_drives.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) $display("unexpected steer_drive %0d", actual);
        return;
      end
      want = expected_drives.pop_front();
      if (want !== actual) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("steer_drive mismatch: expected %0d, got %0d", want, actual);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [OFFSET_W-1:0] in_lane_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DRIVE_W-1:0] out_steer_drive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  drive_scoreboard sb;
  int idle_pct = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int walk_pos = 0;

  steering_pd_nonlinear_gain_filtered_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_lane_offset  (in_lane_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_steer_drive (out_steer_drive),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: check accepted drives, then decide ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_drive(out_steer_drive);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [CFG_DAT_W-1:0] rand_reg(reg_idx_t r);
    case ($urandom_range(0, 4))
      0: return 16'hFFFF;
      1: return 16'd0;
      2: return 16'($urandom);
      3: begin
        if (r == REG_FILT_WEIGHT) return 16'(WEIGHT_ONE);
        if (r == REG_SQ_DIV) return 16'd1;
        return 16'($urandom_range(0, 255));
      end
      default: begin
        if (r == REG_FILT_WEIGHT) return 16'($urandom_range(0, 256));
        if (r == REG_SQ_DIV) return 16'($urandom_range(1, 20000));
        return 16'($urandom_range(0, 4096));
      end
    endcase
  endfunction

  function automatic logic signed [OFFSET_W-1:0] pick_offset();
    int mag;
    case ($urandom_range(0, 6))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      2: mag = $urandom_range(0, 400);
      3, 4: begin
        // slow drift so the derivative term sees small steps
        walk_pos += $urandom_range(0, 400) - 200;
        if (walk_pos > 32767) walk_pos = 32767;
        if (walk_pos < -32768) walk_pos = -32768;
        return 16'(walk_pos);
      end
      default: mag = $urandom_range(0, 12000);
    endcase
    return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic apply_settings(input logic [CFG_DAT_W-1:0] prop, div, deriv, weight,
                                input bit add_bad);
    logic [CFG_IDX_W-1:0] idx[$];
    logic [CFG_DAT_W-1:0] dat[$];
    idx.push_back(REG_PROP_GAIN);   dat.push_back(prop);
    idx.push_back(REG_SQ_DIV);      dat.push_back(div);
    if (add_bad) begin
      idx.push_back(CFG_IDX_W'($urandom_range(NUM_REGS, 255)));
      dat.push_back(16'($urandom));
    end
    idx.push_back(REG_DERIV_GAIN);  dat.push_back(deriv);
    idx.push_back(REG_FILT_WEIGHT); dat.push_back(weight);
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], dat[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic signed [OFFSET_W-1:0] offset);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lane_offset <= offset;
    do @(posedge clk); while (!in_ready);
    sb.note_request(offset);
  endtask

  // send a batch of offsets, then wait until every drive has come back
  task automatic run_offsets(input logic signed [OFFSET_W-1:0] offsets[$]);
    foreach (offsets[i]) send_request(offsets[i]);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic signed [OFFSET_W-1:0] batch[$];
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, field extremes and the edges of the error scaling
    run_offsets('{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd12, -16'sd12});

    // huge gain with zero divisor, full derivative gain, no filtering
    apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b1);
    run_offsets('{16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd0, 16'sh8000});

    // weight of one: output holds
    apply_settings(16'd0, 16'hFFFF, 16'd0, 16'(WEIGHT_ONE), 1'b0);
    run_offsets('{16'sd100, -16'sd5000, 16'sh7FFF});

    // weight above one after masking
    apply_settings(16'd1, 16'd1, 16'd1, 16'hFFFF, 1'b1);
    run_offsets('{16'sh7FFF, 16'sd12, -16'sd11});

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (ph == RAND_PHASES - 1) idle_pct = 0;
      apply_settings(rand_reg(REG_PROP_GAIN), rand_reg(REG_SQ_DIV),
                     rand_reg(REG_DERIV_GAIN), rand_reg(REG_FILT_WEIGHT),
                     $urandom_range(0, 2) == 0);
      batch.delete();
      repeat (PHASE_ITEMS) batch.push_back(pick_offset());
      if (ph == 2) hold_req = 1'b1;
      run_offsets(batch);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) $display("%0d steer_drive results never arrived", sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
